// ===== src/upi_pkg.sv =====
// Shared types and constants of the unicycle pose integrator.
package upi_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_WB,
    ST_TRIG,
    ST_XSAT,
    ST_YSAT,
    ST_DONE
  } state_e;

  // Operations issued to the shared multiplier
  typedef enum logic [3:0] {
    U_ANG,
    U_LIN,
    U_X,
    U_X2,
    U_HMUL,
    U_HREC,
    U_HCHK,
    U_SFIN,
    U_DX0,
    U_DX1,
    U_DY0,
    U_DY1
  } uop_e;

  // Configuration register indexes
  localparam logic [1:0] REG_TIME_STEP  = 2'd0;
  localparam logic [1:0] REG_START_X    = 2'd1;
  localparam logic [1:0] REG_START_Y    = 2'd2;
  localparam logic [1:0] REG_START_HEAD = 2'd3;

  localparam int unsigned CFG_AW = 4;

  localparam logic [15:0] TIME_STEP_RST = 16'd655;

  // pi in Q2.30 (radians per half turn, scaled for the 15-bit shift)
  localparam logic [31:0] PI_Q30  = 32'hC90F_DAA2;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  // Taylor series Horner divisors: sine terms first, then cosine terms
  localparam int unsigned HORNER_N = 11;
  localparam logic [3:0] SIN_LAST = 4'd4;
  localparam logic [3:0] COS_LAST = 4'd10;

  localparam logic [7:0] HORNER_K [HORNER_N] = '{
    8'd110, 8'd72, 8'd42, 8'd20, 8'd6,
    8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
  };

  // floor(2^31 / k): reciprocal for the quotient estimate, one correction step after
  localparam logic [31:0] HORNER_M [HORNER_N] = '{
    32'(64'h8000_0000 / 64'd110), 32'(64'h8000_0000 / 64'd72),
    32'(64'h8000_0000 / 64'd42),  32'(64'h8000_0000 / 64'd20),
    32'(64'h8000_0000 / 64'd6),   32'(64'h8000_0000 / 64'd132),
    32'(64'h8000_0000 / 64'd90),  32'(64'h8000_0000 / 64'd56),
    32'(64'h8000_0000 / 64'd30),  32'(64'h8000_0000 / 64'd12),
    32'(64'h8000_0000 / 64'd2)
  };

endpackage

// ===== src/unicycle_pose_integrator_unit.sv =====
// Top level of the unicycle pose integrator: config registers, sequencer and datapath.
//
// Dead-reckoning pose integrator. A step transaction (tuser = 0) runs its products
// through one 32x32 multiplier that is shared by every product (time-step scaling, the
// sine/cosine Horner series with reciprocal division, and the split 39x(TRIG_BITS+1)
// distance products); each product passes a multiply state and a write-back state.
// A restart transaction (tuser = 1) loads the start pose and goes straight to done. The
// input is not ready while an item is in work; a finished pose waits in the output
// register so the next item can start meanwhile. The user must write configuration
// over the APB-style port only while the block is idle; the block does not enforce it.
module unicycle_pose_integrator_unit
  import upi_pkg::*;
#(
  parameter int unsigned TRIG_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB-style configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [47:0]       s_axis_tdata,  // [23:0] lin_vel, [47:24] ang_vel
  input  logic              s_axis_tuser,  // [0] op
  // Output stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [79:0]       m_axis_tdata   // [31:0] pos_x, [63:32] pos_y, [79:64] heading
);

  localparam int unsigned TW      = TRIG_BITS + 1;            // trig magnitude width
  localparam int unsigned SH      = 16 + TRIG_BITS;           // product to Q16.16 shift
  localparam int unsigned MW      = 64 - SH;                  // rounded delta width
  localparam int unsigned SUMW    = ((MW > 32) ? MW : 32) + 2;
  localparam logic [31:0] TRIG_RND = 32'(1) << (29 - TRIG_BITS);
  localparam logic [63:0] HALF    = 64'(1) << (SH - 1);

  // Round a Q30 value to TRIG_BITS fraction bits, half up
  function automatic logic [TW-1:0] to_trig(input logic [31:0] v);
    logic [31:0] s;
    s = v + TRIG_RND;
    return s[30:30-TRIG_BITS];
  endfunction

  // Saturating add of a signed delta (magnitude and sign) to a Q16.16 position
  function automatic logic [31:0] sat_add(input logic [31:0] cur, input logic [MW-1:0] mag,
                                          input logic neg);
    logic [SUMW-1:0] c;
    logic [SUMW-1:0] d;
    logic [SUMW-1:0] s;
    logic [31:0]     r;
    c = {{(SUMW-32){cur[31]}}, cur};
    d = {{(SUMW-MW){1'b0}}, mag};
    s = neg ? (c - d) : (c + d);
    if (!s[SUMW-1] && (|s[SUMW-2:31])) begin
      r = 32'h7FFF_FFFF;
    end else if (s[SUMW-1] && !(&s[SUMW-2:31])) begin
      r = 32'h8000_0000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  state_e state_q, state_d;
  uop_e   uop_q, uop_d;
  logic [3:0] hidx_q, hidx_d;

  // Config registers and pose state
  logic [15:0] time_step_q;
  logic [31:0] start_x_q;
  logic [31:0] start_y_q;
  logic [15:0] start_head_q;
  logic [31:0] cur_x_q;
  logic [31:0] cur_y_q;
  logic [15:0] cur_head_q;

  // Output register
  logic        m_valid_q;
  logic [79:0] out_q;

  // Scratch datapath registers
  logic [23:0]   lv_q;
  logic [23:0]   av_q;
  logic [15:0]   dh_q;
  logic [38:0]   dmag_q;
  logic          dneg_q;
  logic [31:0]   xa_q;
  logic [31:0]   x2_q;
  logic [31:0]   t_q;
  logic [31:0]   v_q;
  logic [31:0]   quo_q;
  logic [31:0]   sn_q;
  logic [TW-1:0] cmag_q;
  logic [TW-1:0] smag_q;
  logic          cneg_q;
  logic          sneg_q;
  logic [63:0]   prod_q;
  logic [63:0]   acc_q;

  logic s_fire;
  logic out_free;
  logic cfg_wr;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;
  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite;

  // Register readback
  always_comb begin
    unique case (paddr[3:2])
      REG_TIME_STEP:  prdata = {16'd0, time_step_q};
      REG_START_X:    prdata = start_x_q;
      REG_START_Y:    prdata = start_y_q;
      REG_START_HEAD: prdata = {16'd0, start_head_q};
      default:        prdata = '0;
    endcase
  end

  // Heading reduced to the first octant
  logic [13:0] head_off;
  logic        swap;
  logic [13:0] red_ang;
  logic [23:0] lv_mag;

  assign head_off = cur_head_q[13:0];
  assign swap     = head_off > 14'd8192;
  assign red_ang  = swap ? 14'(15'd16384 - {1'b0, head_off}) : head_off;
  assign lv_mag   = lv_q[23] ? 24'(-lv_q) : lv_q;

  // Shared multiplier operand select
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (uop_q)
      U_ANG: begin
        mul_a = {{8{av_q[23]}}, av_q};
        mul_b = {16'd0, time_step_q};
      end
      U_LIN: begin
        mul_a = {8'd0, lv_mag};
        mul_b = {16'd0, time_step_q};
      end
      U_X: begin
        mul_a = {18'd0, red_ang};
        mul_b = PI_Q30;
      end
      U_X2: begin
        mul_a = xa_q;
        mul_b = xa_q;
      end
      U_HMUL: begin
        mul_a = x2_q;
        mul_b = t_q;
      end
      U_HREC: begin
        mul_a = v_q;
        mul_b = HORNER_M[hidx_q];
      end
      U_HCHK: begin
        mul_a = quo_q;
        mul_b = {24'd0, HORNER_K[hidx_q]};
      end
      U_SFIN: begin
        mul_a = xa_q;
        mul_b = t_q;
      end
      U_DX0: begin
        mul_a = dmag_q[31:0];
        mul_b = {{(32-TW){1'b0}}, cmag_q};
      end
      U_DX1: begin
        mul_a = {25'd0, dmag_q[38:32]};
        mul_b = {{(32-TW){1'b0}}, cmag_q};
      end
      U_DY0: begin
        mul_a = dmag_q[31:0];
        mul_b = {{(32-TW){1'b0}}, smag_q};
      end
      U_DY1: begin
        mul_a = {25'd0, dmag_q[38:32]};
        mul_b = {{(32-TW){1'b0}}, smag_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      uop_q   <= U_ANG;
      hidx_q  <= '0;
    end else begin
      state_q <= state_d;
      uop_q   <= uop_d;
      hidx_q  <= hidx_d;
    end
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    uop_d   = uop_q;
    hidx_d  = hidx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          state_d = s_axis_tuser ? ST_DONE : ST_MUL;
          uop_d   = U_ANG;
        end
      end
      ST_MUL: state_d = ST_WB;
      ST_WB: begin
        state_d = ST_MUL;
        unique case (uop_q)
          U_ANG: uop_d = U_LIN;
          U_LIN: uop_d = U_X;
          U_X:   uop_d = U_X2;
          U_X2: begin
            uop_d  = U_HMUL;
            hidx_d = '0;
          end
          U_HMUL: uop_d = U_HREC;
          U_HREC: uop_d = U_HCHK;
          U_HCHK: begin
            hidx_d = hidx_q + 4'd1;
            if (hidx_q == SIN_LAST) begin
              uop_d = U_SFIN;
            end else if (hidx_q == COS_LAST) begin
              state_d = ST_TRIG;
            end else begin
              uop_d = U_HMUL;
            end
          end
          U_SFIN: uop_d = U_HMUL;
          U_DX0:  uop_d = U_DX1;
          U_DX1:  state_d = ST_XSAT;
          U_DY0:  uop_d = U_DY1;
          U_DY1:  state_d = ST_YSAT;
          default: state_d = ST_IDLE;
        endcase
      end
      ST_TRIG: begin
        state_d = ST_MUL;
        uop_d   = U_DX0;
      end
      ST_XSAT: begin
        state_d = ST_MUL;
        uop_d   = U_DY0;
      end
      ST_YSAT: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Horner correction: quotient estimate is low by at most one
  logic [31:0] hrem;
  logic [31:0] hquo;
  assign hrem = v_q - prod_q[31:0];
  assign hquo = quo_q + 32'(hrem >= {24'd0, HORNER_K[hidx_q]});

  // Sine and cosine magnitudes of the reduced angle, swapped across the octant
  logic [TW-1:0] sn_t;
  logic [TW-1:0] cs_t;
  logic [TW-1:0] sq_mag;
  logic [TW-1:0] cq_mag;
  assign sn_t   = to_trig(sn_q);
  assign cs_t   = to_trig(t_q);
  assign sq_mag = swap ? cs_t : sn_t;
  assign cq_mag = swap ? sn_t : cs_t;

  // Config, pose and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q  <= TIME_STEP_RST;
      start_x_q    <= '0;
      start_y_q    <= '0;
      start_head_q <= '0;
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      cur_head_q   <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_TIME_STEP:  time_step_q  <= pwdata[15:0];
          REG_START_X:    start_x_q    <= pwdata;
          REG_START_Y:    start_y_q    <= pwdata;
          REG_START_HEAD: start_head_q <= pwdata[15:0];
          default: ;
        endcase
      end
      if (s_fire && s_axis_tuser) begin
        cur_x_q    <= start_x_q;
        cur_y_q    <= start_y_q;
        cur_head_q <= start_head_q;
      end
      if (state_q == ST_XSAT) begin
        cur_x_q <= sat_add(cur_x_q, acc_q[63:SH], dneg_q ^ cneg_q);
      end
      if (state_q == ST_YSAT) begin
        cur_y_q    <= sat_add(cur_y_q, acc_q[63:SH], dneg_q ^ sneg_q);
        cur_head_q <= cur_head_q + dh_q;
      end
      if (state_q == ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_q <= {cur_head_q, cur_y_q, cur_x_q};
    end
  end

  // Datapath scratch registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      lv_q <= s_axis_tdata[23:0];
      av_q <= s_axis_tdata[47:24];
    end
    if (state_q == ST_MUL) begin
      prod_q <= mul_p;
    end
    if (state_q == ST_TRIG) begin
      unique case (cur_head_q[15:14])
        2'd0: begin
          cmag_q <= cq_mag; cneg_q <= 1'b0;
          smag_q <= sq_mag; sneg_q <= 1'b0;
        end
        2'd1: begin
          cmag_q <= sq_mag; cneg_q <= 1'b1;
          smag_q <= cq_mag; sneg_q <= 1'b0;
        end
        2'd2: begin
          cmag_q <= cq_mag; cneg_q <= 1'b1;
          smag_q <= sq_mag; sneg_q <= 1'b1;
        end
        default: begin
          cmag_q <= sq_mag; cneg_q <= 1'b0;
          smag_q <= cq_mag; sneg_q <= 1'b1;
        end
      endcase
    end
    if (state_q == ST_WB) begin
      case (uop_q)
        U_ANG: dh_q <= 16'((prod_q[31:0] + 32'd32768) >> 16);
        U_LIN: begin
          dmag_q <= prod_q[38:0];
          dneg_q <= lv_q[23];
        end
        U_X: xa_q <= 32'((prod_q[46:0] + 47'd16384) >> 15);
        U_X2: begin
          x2_q <= prod_q[61:30];
          t_q  <= ONE_Q30;
        end
        U_HMUL: v_q   <= prod_q[61:30];
        U_HREC: quo_q <= prod_q[62:31];
        U_HCHK: t_q   <= ONE_Q30 - hquo;
        U_SFIN: begin
          sn_q <= prod_q[61:30];
          t_q  <= ONE_Q30;
        end
        U_DX0, U_DY0: acc_q <= prod_q;
        U_DX1, U_DY1: acc_q <= acc_q + {prod_q[31:0], 32'd0} + HALF;
        default: ;
      endcase
    end
  end

endmodule

// ===== sim/unicycle_pose_integrator_unit_tb.sv =====
// Self-checking testbench for the unicycle pose integrator: stream stimulus, pose predictor.
`timescale 1ns / 100ps

module unicycle_pose_integrator_unit_tb
  import upi_pkg::*;
();

  localparam int TRIG_BITS      = 16;
  localparam int HOLD_CYCLES    = 400;   // receiver hold-off for the pressure phase
  localparam int DRAIN_CYCLES   = 120;
  localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles: hold-off plus a step, many times over
  localparam int PHASE_ITEMS    = 90;

  localparam logic OP_STEP    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [23:0] VEL_MAX = 24'h7F_FFFF;
  localparam logic [23:0] VEL_MIN = 24'h80_0000;

  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint unsigned PI_Q2_30 = 64'hC90F_DAA2;
  // Horner divisors, first term in the low byte
  localparam logic [39:0] SIN_DIV = {8'd6, 8'd20, 8'd42, 8'd72, 8'd110};
  localparam logic [47:0] COS_DIV = {8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};

  // Laid out like m_axis_tdata: heading on top, pos_x in the low bits
  typedef struct packed {
    logic [15:0] heading;
    logic [31:0] y;
    logic [31:0] x;
  } pose_t;

  // Directed row: optional register write, then one transaction
  typedef struct packed {
    logic        wr;
    logic [1:0]  idx;
    logic [31:0] val;
    logic        op;
    logic [23:0] lin;
    logic [23:0] ang;
    logic        known;
    logic [31:0] ex;
    logic [31:0] ey;
    logic [15:0] eh;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // [23:0] lin_vel, [47:24] ang_vel
  logic        s_axis_tuser = 1'b0; // [0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;        // [31:0] pos_x, [63:32] pos_y, [79:64] heading

  // Predictor copy of configuration and pose
  logic [15:0] cfg_time_step = 16'd655;
  logic [31:0] cfg_start_x = '0;
  logic [31:0] cfg_start_y = '0;
  logic [15:0] cfg_start_heading = '0;
  logic [31:0] pose_x = '0;
  logic [31:0] pose_y = '0;
  logic [15:0] pose_heading = '0;

  pose_t    pose_q[$];
  dir_row_t dir_rows[$];
  pose_t    got_pose, want_pose;
  int       errors = 0;
  int       quiet_cycles = 0;
  int       src_idle_pct = 0;
  int       sink_stall_pct = 0;
  bit       hold_req = 1'b0;

  unicycle_pose_integrator_unit #(.TRIG_BITS(TRIG_BITS)) uut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  // Sine and cosine of a binary angle, TRIG_BITS fraction bits
  function automatic void heading_trig(input logic [15:0] h, output longint cos_v,
                                       output longint sin_v);
    longint unsigned r, rad, rad2, t, sn, cs;
    longint sq, cq;
    bit mirror;
    r = longint'(h[13:0]);
    mirror = r > 8192;
    if (mirror) r = 16384 - r;
    rad = (r * PI_Q2_30 + 16384) >> 15;
    rad2 = (rad * rad) >> 30;
    t = Q30_ONE;
    for (int i = 0; i < 5; i++) t = Q30_ONE - ((rad2 * t) >> 30) / SIN_DIV[8*i +: 8];
    sn = (rad * t) >> 30;
    t = Q30_ONE;
    for (int i = 0; i < 6; i++) t = Q30_ONE - ((rad2 * t) >> 30) / COS_DIV[8*i +: 8];
    cs = t;
    // round half up from Q30, swap across the octant
    sq = longint'(((mirror ? cs : sn) + (64'd1 << (29 - TRIG_BITS))) >> (30 - TRIG_BITS));
    cq = longint'(((mirror ? sn : cs) + (64'd1 << (29 - TRIG_BITS))) >> (30 - TRIG_BITS));
    case (h[15:14])
      2'd0: begin cos_v = cq;  sin_v = sq;  end
      2'd1: begin cos_v = -sq; sin_v = cq;  end
      2'd2: begin cos_v = -cq; sin_v = -sq; end
      default: begin cos_v = sq; sin_v = -cq; end
    endcase
  endfunction

  // Q8.(32+TRIG_BITS) product to Q16.16, half away from zero
  function automatic longint round_q16(input longint p);
    longint unsigned m;
    m = (p < 0) ? longint'(-p) : longint'(p);
    m = (m + (64'd1 << (15 + TRIG_BITS))) >> (16 + TRIG_BITS);
    return (p < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [31:0] clamp_add(input logic [31:0] cur, input longint delta);
    longint v;
    v = longint'($signed(cur)) + delta;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // Advance the predicted pose by one transaction
  function automatic pose_t advance_pose(input logic op, input logic [23:0] lin,
                                         input logic [23:0] ang);
    longint lin_dist, c, s, turn;
    if (op == OP_RESTART) begin
      pose_x = cfg_start_x;
      pose_y = cfg_start_y;
      pose_heading = cfg_start_heading;
    end else begin
      lin_dist = longint'($signed(lin)) * longint'(cfg_time_step);
      heading_trig(pose_heading, c, s);
      pose_x = clamp_add(pose_x, round_q16(lin_dist * c));
      pose_y = clamp_add(pose_y, round_q16(lin_dist * s));
      turn = longint'($signed(ang)) * longint'(cfg_time_step) + 32768;
      pose_heading = pose_heading + turn[31:16];
    end
    return '{heading: pose_heading, y: pose_y, x: pose_x};
  endfunction

  // Offer one transaction at the falling edge; predict once it is taken
  task automatic send_item(input logic op, input logic [23:0] lin, input logic [23:0] ang,
                           input logic known, input pose_t typed);
    pose_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ang, lin};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = advance_pose(op, lin, ang);
    pose_q.push_back(known ? typed : predicted);
    @(negedge clk_i);
  endtask

  // Drop valid and let every pose come back before touching registers
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pose_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Register write, then read back
  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] kept, readback;
    kept = (idx == REG_TIME_STEP || idx == REG_START_HEAD) ? {16'd0, val[15:0]} : val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_TIME_STEP:  cfg_time_step = kept[15:0];
      REG_START_X:    cfg_start_x = kept;
      REG_START_Y:    cfg_start_y = kept;
      REG_START_HEAD: cfg_start_heading = kept[15:0];
      default: ;
    endcase
    if (readback !== kept) begin
      $display("%0t: register %0d readback mismatch: expected %h, actual %h",
               $time, idx, kept, readback);
      errors++;
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      errors++;
    end
  endtask

  // Output monitor: each pose transaction against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_pose = pose_t'(m_axis_tdata);
      if (pose_q.size() == 0) begin
        $display("%0t: unexpected pose transaction: expected none, actual %h",
                 $time, m_axis_tdata);
        errors++;
      end else begin
        want_pose = pose_q.pop_front();
        check_field("pos_x", want_pose.x, got_pose.x);
        check_field("pos_y", want_pose.y, got_pose.y);
        check_field("heading", {16'd0, want_pose.heading}, {16'd0, got_pose.heading});
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : sink_proc
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : main_seq
    logic        op;
    logic [23:0] lin, ang;
    logic [15:0] ts_val;
    dir_row_t    row;

    // Directed rows: wr, register, value, op, lin, ang, known, x, y, heading
    dir_rows.push_back('{1'b0, REG_TIME_STEP, 32'd0, OP_STEP, 24'd0, 24'd0,
                         1'b1, 32'd0, 32'd0, 16'd0});
    dir_rows.push_back('{1'b0, REG_TIME_STEP, 32'd0, OP_STEP, VEL_MAX, 24'd0,
                         1'b1, 32'd83840, 32'd0, 16'd0});
    dir_rows.push_back('{1'b0, REG_TIME_STEP, 32'd0, OP_RESTART, VEL_MAX, VEL_MAX,
                         1'b1, 32'd0, 32'd0, 16'd0});
    dir_rows.push_back('{1'b0, REG_TIME_STEP, 32'd0, OP_STEP, VEL_MIN, 24'd0,
                         1'b1, 32'hFFFE_B880, 32'd0, 16'd0});
    dir_rows.push_back('{1'b0, REG_TIME_STEP, 32'd0, OP_STEP, 24'd0, VEL_MAX,
                         1'b1, 32'hFFFE_B880, 32'd0, 16'd18304});
    dir_rows.push_back('{1'b0, REG_TIME_STEP, 32'd0, OP_STEP, VEL_MAX, VEL_MIN,
                         1'b0, 32'd0, 32'd0, 16'd0});
    dir_rows.push_back('{1'b0, REG_TIME_STEP, 32'd0, OP_STEP, 24'h12_3456, 24'h01_0000,
                         1'b0, 32'd0, 32'd0, 16'd0});
    // zero time step: a step leaves the pose alone
    dir_rows.push_back('{1'b1, REG_TIME_STEP, 32'd0, OP_RESTART, 24'd0, 24'd0,
                         1'b1, 32'd0, 32'd0, 16'd0});
    dir_rows.push_back('{1'b0, REG_TIME_STEP, 32'd0, OP_STEP, VEL_MAX, VEL_MAX,
                         1'b1, 32'd0, 32'd0, 16'd0});
    // octant edge, just past it, quadrant edge, last angle before the wrap
    dir_rows.push_back('{1'b1, REG_START_HEAD, 32'd8192, OP_RESTART, 24'd0, 24'd0,
                         1'b1, 32'd0, 32'd0, 16'd8192});
    dir_rows.push_back('{1'b1, REG_TIME_STEP, 32'hFFFF, OP_STEP, VEL_MAX, 24'd0,
                         1'b0, 32'd0, 32'd0, 16'd0});
    dir_rows.push_back('{1'b1, REG_START_HEAD, 32'd8193, OP_RESTART, 24'd0, 24'd0,
                         1'b1, 32'd0, 32'd0, 16'd8193});
    dir_rows.push_back('{1'b0, REG_TIME_STEP, 32'd0, OP_STEP, VEL_MIN, VEL_MIN,
                         1'b0, 32'd0, 32'd0, 16'd0});
    dir_rows.push_back('{1'b1, REG_START_HEAD, 32'd16384, OP_RESTART, 24'd0, 24'd0,
                         1'b1, 32'd0, 32'd0, 16'd16384});
    dir_rows.push_back('{1'b0, REG_TIME_STEP, 32'd0, OP_STEP, VEL_MAX, 24'd1,
                         1'b0, 32'd0, 32'd0, 16'd0});
    dir_rows.push_back('{1'b1, REG_START_HEAD, 32'hFFFF, OP_RESTART, 24'd0, 24'd0,
                         1'b1, 32'd0, 32'd0, 16'hFFFF});
    dir_rows.push_back('{1'b0, REG_TIME_STEP, 32'd0, OP_STEP, VEL_MAX, VEL_MAX,
                         1'b0, 32'd0, 32'd0, 16'd0});
    // position saturation at both ends
    dir_rows.push_back('{1'b1, REG_START_X, 32'h7FFF_FFFF, OP_RESTART, 24'd0, 24'd0,
                         1'b1, 32'h7FFF_FFFF, 32'd0, 16'hFFFF});
    dir_rows.push_back('{1'b1, REG_START_HEAD, 32'd0, OP_RESTART, 24'd0, 24'd0,
                         1'b1, 32'h7FFF_FFFF, 32'd0, 16'd0});
    dir_rows.push_back('{1'b0, REG_TIME_STEP, 32'd0, OP_STEP, VEL_MAX, 24'd0,
                         1'b1, 32'h7FFF_FFFF, 32'd0, 16'd0});
    dir_rows.push_back('{1'b1, REG_START_Y, 32'h8000_0000, OP_RESTART, 24'd0, 24'd0,
                         1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0});
    dir_rows.push_back('{1'b1, REG_START_HEAD, 32'hC000, OP_RESTART, 24'd0, 24'd0,
                         1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 16'hC000});
    dir_rows.push_back('{1'b0, REG_TIME_STEP, 32'd0, OP_STEP, VEL_MAX, 24'd0,
                         1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 16'hC000});
    dir_rows.push_back('{1'b0, REG_TIME_STEP, 32'd0, OP_STEP, VEL_MIN, VEL_MIN,
                         1'b0, 32'd0, 32'd0, 16'd0});
    dir_rows.push_back('{1'b1, REG_START_X, 32'h8000_0000, OP_RESTART, 24'd0, 24'd0,
                         1'b1, 32'h8000_0000, 32'h8000_0000, 16'hC000});

    // Reset
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part
    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      if (row.wr) begin
        wait_idle();
        cfg_write(row.idx, row.val);
      end
      send_item(row.op, row.lin, row.ang, row.known, '{heading: row.eh, y: row.ey, x: row.ex});
    end

    // Random phases, each with its own configuration and idling
    for (int phase = 0; phase < 5; phase++) begin
      wait_idle();
      case (phase)
        0: ts_val = 16'hFFFF;
        1: ts_val = 16'd1;
        2: ts_val = 16'd655;
        default: ts_val = 16'($urandom_range(65535));
      endcase
      cfg_write(REG_TIME_STEP, {16'd0, ts_val});
      cfg_write(REG_START_X, (phase == 1) ? 32'h7FFF_FFFF : $urandom);
      cfg_write(REG_START_Y, (phase == 2) ? 32'h8000_0000 : $urandom);
      cfg_write(REG_START_HEAD, 32'($urandom_range(65535)));
      case (phase)
        1: begin src_idle_pct = 80; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 80; end
        3: begin src_idle_pct = 21; sink_stall_pct = 21; end
        default: begin src_idle_pct = 0; sink_stall_pct = 0; end
      endcase
      if (phase == 4) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op  = ($urandom_range(9) == 0) ? OP_RESTART : OP_STEP;
        lin = 24'($urandom);
        ang = 24'($urandom);
        case ($urandom_range(3))
          0: lin = $urandom_range(1) ? VEL_MAX : VEL_MIN;
          1: lin = {{8{lin[23]}}, lin[15:0]};
          default: ;
        endcase
        if ($urandom_range(2) == 0) ang = {{10{ang[23]}}, ang[13:0]};
        send_item(op, lin, ang, 1'b0, '0);
      end
    end

    // Drain
    s_axis_tvalid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== unicycle_pose_integrator_unit.f =====
src/upi_pkg.sv
src/unicycle_pose_integrator_unit.sv
sim/unicycle_pose_integrator_unit_tb.sv
